[src/sss_pkg.sv]
package sss_pkg;

    // Fixed widths of the item fields and configuration registers.
    localparam int BYTE_W          = 8;
    localparam int MATCH_OFFSET_W  = 32;
    localparam int NEEDLE_HALF_W   = 64;
    localparam int NEEDLE_W        = 2 * NEEDLE_HALF_W;
    localparam int NEEDLE_LEN_W    = 5;
    localparam int CFG_INDEX_W     = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_NEEDLE_BYTES = 16;
    localparam int DEF_OFFSET_BITS      = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_FIRST_HALF  = 2'd0,
        CFG_NEEDLE_SECOND_HALF = 2'd1,
        CFG_NEEDLE_LENGTH      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_haystack;
    } hay_item_t;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } res_item_t;

endpackage

[src/sss_window_cmp.sv]
module sss_window_cmp #(
    parameter int MAX_NEEDLE_BYTES = 16,
    parameter int HIST_DEPTH       = 15
) (
    input  logic [sss_pkg::BYTE_W-1:0]                  cur_byte,
    input  logic [HIST_DEPTH-1:0][sss_pkg::BYTE_W-1:0]  hist,
    input  logic [sss_pkg::NEEDLE_W-1:0]                needle,
    input  logic [sss_pkg::NEEDLE_LEN_W-1:0]            needle_size,
    output logic                                        window_hit
);
    import sss_pkg::*;

    // Window byte k is the byte that arrived k items ago; k = 0 is the current one.
    logic [MAX_NEEDLE_BYTES-1:0][BYTE_W-1:0] window;
    logic [MAX_NEEDLE_BYTES-1:0]             hit_by_len;
    logic [MAX_NEEDLE_BYTES-1:0]             len_sel;

    assign window[0] = cur_byte;

    for (genvar k = 1; k < MAX_NEEDLE_BYTES; k++) begin : g_window
        assign window[k] = hist[k-1];
    end

    // For needle length n, needle byte i lines up with window byte n-1-i.
    for (genvar n = 1; n <= MAX_NEEDLE_BYTES; n++) begin : g_len
        logic [n-1:0] byte_eq;
        for (genvar i = 0; i < n; i++) begin : g_byte
            assign byte_eq[i] = (window[n-1-i] == needle[BYTE_W*i +: BYTE_W]);
        end
        assign hit_by_len[n-1] = &byte_eq;
        assign len_sel[n-1]    = (needle_size == NEEDLE_LEN_W'(n));
    end

    // Lengths above the supported maximum select nothing and never hit.
    assign window_hit = |(hit_by_len & len_sel);

endmodule

[src/streaming_substring_search.sv]
// Streaming substring search.
//
// Haystack bytes enter on the hay channel (hay_valid / hay_stall / hay_item),
// one byte per item, with end_of_haystack set on the final byte. Exactly one
// result leaves on the res channel (res_valid / res_stall / res_item) for each
// haystack: found, and the offset of the first occurrence of the needle
// (0 when not found). Bytes that are not final give no result.
//
// The user writes the needle (up to MAX_NEEDLE_BYTES bytes) and its length
// on cfg only while the block is idle (not enforced); cfg_ready is always high.
//
// Throughput: one item per cycle while the hay channel is not stalled. An item
// is captured in an input register, compared against the needle over the full
// window, and the result lands in the output register: the result of a final
// byte passes from the input register through the output register to res.
// When the receiver stalls, the result is held; non-final bytes still flow,
// and the next final byte waits in the input register, which stalls the hay
// channel until the output register frees.
// Reset clears the needle, the byte count and both valid flags.
module streaming_substring_search #(
    parameter int MAX_NEEDLE_BYTES = sss_pkg::DEF_MAX_NEEDLE_BYTES,
    parameter int OFFSET_BITS      = sss_pkg::DEF_OFFSET_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // haystack channel
    input  logic                                hay_valid,
    output logic                                hay_stall,
    input  sss_pkg::hay_item_t                  hay_item,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output sss_pkg::res_item_t                  res_item,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sss_pkg::NEEDLE_HALF_W-1:0]   cfg_data
);
    import sss_pkg::*;

    // History keeps the previous MAX_NEEDLE_BYTES-1 bytes (at least one entry).
    localparam int HIST_DEPTH = (MAX_NEEDLE_BYTES > 1) ? MAX_NEEDLE_BYTES - 1 : 1;

    // Configuration registers
    logic [NEEDLE_HALF_W-1:0] needle_lo_reg;
    logic [NEEDLE_HALF_W-1:0] needle_hi_reg;
    logic [NEEDLE_LEN_W-1:0]  needle_size_reg;

    // Input register
    logic      item_valid_reg;
    hay_item_t item_reg;

    // Search state
    logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_reg, hist_next;
    logic [OFFSET_BITS-1:0]            seen_reg, seen_next;
    logic                              matched_reg, matched_next;
    logic [OFFSET_BITS-1:0]            first_off_reg, first_off_next;

    // Output register
    logic      res_valid_reg;
    res_item_t res_item_reg;

    logic hay_accept;
    logic res_free;
    logic advance;
    logic window_hit;
    logic len_fits;

    // ------------------------------------------------------------------
    // Configuration: always ready, takes effect on the next item.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_lo_reg   <= '0;
            needle_hi_reg   <= '0;
            needle_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NEEDLE_FIRST_HALF:  needle_lo_reg   <= cfg_data;
                CFG_NEEDLE_SECOND_HALF: needle_hi_reg   <= cfg_data;
                CFG_NEEDLE_LENGTH:      needle_size_reg <= cfg_data[NEEDLE_LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a non-final byte always advances; a final byte advances
    // only when the output register is empty or being drained.
    // ------------------------------------------------------------------
    assign res_free   = !res_valid_reg || !res_stall;
    assign advance    = item_valid_reg && (!item_reg.end_of_haystack || res_free);
    assign hay_stall  = item_valid_reg && !advance;
    assign hay_accept = hay_valid && !hay_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (hay_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hay_accept)
        begin
            item_reg <= hay_item;
        end
    end

    // ------------------------------------------------------------------
    // Window compare against the needle
    // ------------------------------------------------------------------
    sss_window_cmp #(
        .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES),
        .HIST_DEPTH       (HIST_DEPTH)
    ) u_cmp (
        .cur_byte    (item_reg.data_byte),
        .hist        (hist_reg),
        .needle      ({needle_hi_reg, needle_lo_reg}),
        .needle_size (needle_size_reg),
        .window_hit  (window_hit)
    );

    assign len_fits = (32'(needle_size_reg) <= 32'(MAX_NEEDLE_BYTES));

    // ------------------------------------------------------------------
    // Search state update for the item in the input register
    // ------------------------------------------------------------------
    always_comb
    begin
        // Saturating byte count.
        seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;

        matched_next   = matched_reg;
        first_off_next = first_off_reg;
        if (!matched_reg)
        begin
            if (needle_size_reg == '0)
            begin
                // Empty needle matches at the start.
                matched_next   = 1'b1;
                first_off_next = '0;
            end
            else if (len_fits && (seen_next >= OFFSET_BITS'(needle_size_reg)) && window_hit)
            begin
                matched_next   = 1'b1;
                first_off_next = seen_next - OFFSET_BITS'(needle_size_reg);
            end
        end

        // Shift the current byte into the history.
        hist_next[0] = item_reg.data_byte;
        for (int k = 1; k < HIST_DEPTH; k++)
        begin
            hist_next[k] = hist_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            matched_reg   <= 1'b0;
            first_off_reg <= '0;
        end
        else if (advance)
        begin
            if (item_reg.end_of_haystack)
            begin
                // Clear for the next haystack.
                seen_reg      <= '0;
                matched_reg   <= 1'b0;
                first_off_reg <= '0;
            end
            else
            begin
                seen_reg      <= seen_next;
                matched_reg   <= matched_next;
                first_off_reg <= first_off_next;
            end
        end
    end

    // History needs no reset: the byte count keeps stale bytes out of compares.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_reg <= hist_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && item_reg.end_of_haystack)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_reg.end_of_haystack)
        begin
            res_item_reg.found        <= matched_next;
            res_item_reg.match_offset <= matched_next ?
                                         MATCH_OFFSET_W'(first_off_next) : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

[src/sss_checker.sv]
module sss_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hay_valid,
    input  logic                                hay_stall,
    input  sss_pkg::hay_item_t                  hay_item,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  sss_pkg::res_item_t                  res_item
);
    import sss_pkg::*;

    // A stalled result stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result dropped or changed");

    // No match means a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.found || (res_item.match_offset == '0))
        else $error("nonzero offset without a match");

    // A final byte taken while the result is held must back up the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall && hay_valid && !hay_stall && hay_item.end_of_haystack)
        ##1 res_stall |-> hay_stall)
        else $error("second result would overrun the held result");

    // The input backs up only behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        hay_stall |-> res_valid && res_stall)
        else $error("input stalled without a held result");

endmodule

bind streaming_substring_search sss_checker u_sss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hay_valid (hay_valid),
    .hay_stall (hay_stall),
    .hay_item  (hay_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

[test/tb_streaming_substring_search.sv]
`timescale 1ns / 1ps

module tb_streaming_substring_search;

    import sss_pkg::*;

    // Cycles to let pass once nothing is pending: accept -> input register ->
    // compare -> output register, plus margin.
    localparam int DRAIN_CYCLES = 8;
    // Hard stop for the whole run, far above the slowest correct run.
    localparam int RUN_LIMIT    = 300000;
    localparam int WINDOW_DEPTH = 15;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    logic                     clk;
    logic                     rst_n;
    logic                     hay_valid;
    logic                     hay_stall;
    hay_item_t                hay_item;
    logic                     res_valid;
    logic                     res_stall;
    res_item_t                res_item;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [NEEDLE_HALF_W-1:0] cfg_data;

    // Search state mirrored by the predictor
    logic [NEEDLE_W-1:0]       needle_bits;
    logic [NEEDLE_LEN_W-1:0]   needle_size;
    logic [BYTE_W-1:0]         window_bytes[WINDOW_DEPTH];
    logic [MATCH_OFFSET_W-1:0] hay_count;
    logic                      hit_seen;
    logic [MATCH_OFFSET_W-1:0] hit_offset;

    res_item_t pending_results[$];

    int error_count;
    int items_sent;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    streaming_substring_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hay_valid (hay_valid),
        .hay_stall (hay_stall),
        .hay_item  (hay_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run ends long before this.
    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Drive the result-side stall at the falling edge. A long hold-off,
    // when requested, takes priority over the random stall rate.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall = 1'b1;
                hold_cycles--;
            end
            else
            begin
                res_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Clear the per-haystack search state, as the block does after a final byte.
    function automatic void clear_search();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            window_bytes[i] = '0;
        hay_count  = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    // Advance the search by one haystack byte; queue the result on a final byte.
    function automatic void search_step(input logic [BYTE_W-1:0] cur, input logic last);
        int        n;
        bit        eq;
        res_item_t want;
        n = needle_size;
        // Saturate the byte count at its maximum
        if (hay_count != '1)
            hay_count++;
        if (!hit_seen)
        begin
            if (n == 0)
            begin
                hit_seen   = 1'b1;
                hit_offset = '0;
            end
            else if (n <= DEF_MAX_NEEDLE_BYTES && hay_count >= n)
            begin
                // Newest byte is the last needle byte; older ones come from the window
                eq = (needle_bits[8*(n-1) +: 8] == cur);
                for (int i = 0; i + 1 < n; i++)
                    if (window_bytes[n-2-i] != needle_bits[8*i +: 8])
                        eq = 1'b0;
                if (eq)
                begin
                    hit_seen   = 1'b1;
                    hit_offset = hay_count - n;
                end
            end
        end
        for (int i = WINDOW_DEPTH - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
        window_bytes[0] = cur;
        if (last)
        begin
            want.found        = hit_seen;
            want.match_offset = hit_seen ? hit_offset : '0;
            pending_results.push_back(want);
            clear_search();
        end
    endfunction

    // Check each accepted result against the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing pending: found %0b, match_offset %0d",
                       res_item.found, res_item.match_offset);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_item.found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, res_item.found);
                    error_count++;
                end
                if (res_item.match_offset !== want.match_offset)
                begin
                    $error("match_offset: expected %0d, got %0d",
                           want.match_offset, res_item.match_offset);
                    error_count++;
                end
            end
        end
    end

    // Write one register. Call at a falling edge; returns at a falling edge.
    task automatic write_reg(input cfg_index_t idx, input logic [NEEDLE_HALF_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NEEDLE_FIRST_HALF:  needle_bits[NEEDLE_HALF_W-1:0]        = value;
            CFG_NEEDLE_SECOND_HALF: needle_bits[NEEDLE_W-1:NEEDLE_HALF_W] = value;
            CFG_NEEDLE_LENGTH:      needle_size = value[NEEDLE_LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one haystack byte, with random idle cycles ahead of it.
    // Call at a falling edge; returns at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hay_valid = 1'b0;
            @(negedge clk);
        end
        hay_valid                = 1'b1;
        hay_item.data_byte       = b;
        hay_item.end_of_haystack = last;
        // Hold the item until the block takes it
        do @(posedge clk); while (hay_stall);
        search_step(b, last);
        items_sent++;
        @(negedge clk);
        hay_valid = 1'b0;
    endtask

    task automatic send_haystack(input byte_q_t hs);
        foreach (hs[i])
            send_byte(hs[i], i == hs.size() - 1);
    endtask

    // Stop sending until every expected result has come, then let the
    // pipeline settle so that the block is idle.
    task automatic wait_results_drained();
        hay_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Build a haystack mostly from needle bytes, often with the needle (or a
    // cut-off piece of it at the end) planted inside; some are pure noise.
    function automatic byte_q_t random_haystack();
        byte_q_t hs;
        int      len;
        int      pos;
        int      n;
        bit      noise;
        len   = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(20, 1);
        noise = ($urandom_range(99) < 12);
        n     = needle_size;
        for (int i = 0; i < len; i++)
        begin
            if (noise || n == 0 || n > DEF_MAX_NEEDLE_BYTES || $urandom_range(99) < 25)
                hs.push_back(BYTE_W'($urandom_range(255)));
            else
                hs.push_back(needle_bits[8*$urandom_range(n-1, 0) +: 8]);
        end
        if (!noise && n >= 1 && n <= DEF_MAX_NEEDLE_BYTES && $urandom_range(99) < 55)
        begin
            pos = $urandom_range(len - 1, 0);
            for (int i = 0; i < n && pos + i < len; i++)
                hs[pos+i] = needle_bits[8*i +: 8];
        end
        return hs;
    endfunction

    // Load a random needle: sometimes built from two byte values so that
    // partial and overlapping matches are frequent, sometimes all ones or zeros.
    task automatic load_random_needle();
        logic [NEEDLE_W-1:0]      nb;
        logic [BYTE_W-1:0]        pool_a;
        logic [BYTE_W-1:0]        pool_b;
        logic [NEEDLE_HALF_W-1:0] len_word;
        bit                       narrow;
        int                       r;
        int                       len;
        narrow = ($urandom_range(99) < 35);
        pool_a = BYTE_W'($urandom);
        pool_b = BYTE_W'($urandom);
        for (int i = 0; i < DEF_MAX_NEEDLE_BYTES; i++)
            nb[8*i +: 8] = narrow ? ($urandom_range(1) ? pool_a : pool_b) : BYTE_W'($urandom);
        r = $urandom_range(99);
        if (r < 5)
            nb = '1;
        else if (r < 10)
            nb = '0;
        write_reg(CFG_NEEDLE_FIRST_HALF, nb[NEEDLE_HALF_W-1:0]);
        write_reg(CFG_NEEDLE_SECOND_HALF, nb[NEEDLE_W-1:NEEDLE_HALF_W]);
        r = $urandom_range(99);
        if (r < 8)
            len = 0;
        else if (r < 15)
            len = $urandom_range(31, DEF_MAX_NEEDLE_BYTES + 1);
        else if (r < 27)
            len = DEF_MAX_NEEDLE_BYTES;
        else
            len = $urandom_range(DEF_MAX_NEEDLE_BYTES - 1, 1);
        // Upper bits of the length word are don't-care; set them now and then
        len_word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
        len_word[NEEDLE_LEN_W-1:0] = NEEDLE_LEN_W'(len);
        write_reg(CFG_NEEDLE_LENGTH, len_word);
    endtask

    // Registers still at reset: the empty needle matches at offset 0.
    task automatic test_empty_needle_at_reset();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Full 16-byte needle equal to the whole haystack: match at offset 0.
    task automatic test_full_length_needle();
        wait_results_drained();
        write_reg(CFG_NEEDLE_FIRST_HALF, '1);
        write_reg(CFG_NEEDLE_SECOND_HALF, '0);
        write_reg(CFG_NEEDLE_LENGTH, NEEDLE_HALF_W'(DEF_MAX_NEEDLE_BYTES));
        for (int i = 0; i < DEF_MAX_NEEDLE_BYTES; i++)
            send_byte((i < 8) ? 8'hFF : 8'h00, i == DEF_MAX_NEEDLE_BYTES - 1);
    endtask

    // A haystack shorter than the needle misses, and the bytes it leaves in
    // the window must not complete the needle in the next haystack.
    task automatic test_short_and_stale();
        wait_results_drained();
        write_reg(CFG_NEEDLE_FIRST_HALF, 64'h0000_0000_0033_2211);
        write_reg(CFG_NEEDLE_LENGTH, 64'd3);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h33, 1'b1);
    endtask

    // Shrink the needle between two bytes of one haystack.
    task automatic test_length_change_mid_haystack();
        wait_results_drained();
        write_reg(CFG_NEEDLE_FIRST_HALF, 64'h0000_0000_0000_2211);
        write_reg(CFG_NEEDLE_LENGTH, 64'd2);
        send_byte(8'h33, 1'b0);
        wait_results_drained();
        write_reg(CFG_NEEDLE_LENGTH, 64'd1);
        send_byte(8'h11, 1'b1);
    endtask

    // Lengths beyond the needle store never match.
    task automatic test_oversized_length();
        wait_results_drained();
        write_reg(CFG_NEEDLE_LENGTH, '1);
        send_byte(8'h11, 1'b1);
        wait_results_drained();
        write_reg(CFG_NEEDLE_LENGTH, NEEDLE_HALF_W'(DEF_MAX_NEEDLE_BYTES + 1));
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    // Random haystacks under one idling and stall setting, with a new needle every so often.
    task automatic test_random_traffic(input int idle_pct, input int stall_rate,
                                       input int quota);
        int start_count;
        int since_load;
        int mark;
        wait_results_drained();
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        start_count   = items_sent;
        since_load    = 1000;
        while (items_sent - start_count < quota)
        begin
            if (since_load >= 60)
            begin
                wait_results_drained();
                load_random_needle();
                since_load = 0;
            end
            mark = items_sent;
            send_haystack(random_haystack());
            since_load += items_sent - mark;
        end
    endtask

    // Hold off the receiver for a long stretch while short haystacks keep
    // coming, so the block fills and stalls its input; then pause the sender
    // until every result is in.
    task automatic test_input_backpressure();
        byte_q_t hs;
        wait_results_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
        load_random_needle();
        hold_cycles = 400;
        repeat (60)
        begin
            hs = random_haystack();
            while (hs.size() > 2)
                void'(hs.pop_front());
            send_haystack(hs);
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        hay_valid     = 1'b0;
        hay_item      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        error_count   = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        needle_bits   = '0;
        needle_size   = '0;
        clear_search();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_needle_at_reset();
        test_full_length_needle();
        test_short_and_stale();
        test_length_change_mid_haystack();
        test_oversized_length();
        test_random_traffic(0, 0, 230);
        test_random_traffic(86, 0, 230);
        test_random_traffic(0, 86, 230);
        test_random_traffic(13, 13, 230);
        test_input_backpressure();

        wait_results_drained();
        if (pending_results.size() != 0)
        begin
            $error("%0d result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/sss_pkg.sv
src/sss_window_cmp.sv
src/streaming_substring_search.sv
src/sss_checker.sv
test/tb_streaming_substring_search.sv
